[sv/swhr_pkg.sv]
// Shared constants and types for the single-wire humidity sensor reader.
package swhr_pkg;

	localparam int FRAME_BITS = 40;
	localparam int WORD_W     = 40;
	localparam int COUNT_W    = 15;
	localparam int BIT_IDX_W  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_TIMEOUT = 3'd4;

	localparam logic [14:0] START_LOW_RESET    = 15'd18000;
	localparam logic [7:0]  RELEASE_RESET      = 8'd30;
	localparam logic [7:0]  RESP_TIMEOUT_RESET = 8'd100;
	localparam logic [7:0]  ONE_THRESH_RESET   = 8'd65;
	localparam logic [7:0]  DATA_TIMEOUT_RESET = 8'd255;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef struct packed {
		logic [14:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  response_timeout;
		logic [7:0]  one_threshold;
		logic [7:0]  data_timeout;
	} cfg_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic       busy_res;
		logic       done_res;
		logic       checksum_ok;
		logic       timed_out;
		logic [7:0] humidity_int;
		logic [7:0] humidity_dec;
		logic [7:0] temperature_int;
		logic [7:0] temperature_dec;
	} res_t;

endpackage

[sv/swhr_ifs.sv]
// Handshake channel interfaces: input items, result items and register writes.
interface swhr_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic line_in;

	modport source (output valid, output kind, output line_in, input ready);
	modport sink (input valid, input kind, input line_in, output ready);
endinterface

interface swhr_out_if;
	logic       valid;
	logic       ready;
	logic       drive_enable;
	logic       drive_level;
	logic       busy_res;
	logic       done_res;
	logic       checksum_ok;
	logic       timed_out;
	logic [7:0] humidity_int;
	logic [7:0] humidity_dec;
	logic [7:0] temperature_int;
	logic [7:0] temperature_dec;

	modport source (output valid, output drive_enable, output drive_level, output busy_res,
		output done_res, output checksum_ok, output timed_out, output humidity_int,
		output humidity_dec, output temperature_int, output temperature_dec, input ready);
	modport sink (input valid, input drive_enable, input drive_level, input busy_res,
		input done_res, input checksum_ok, input timed_out, input humidity_int,
		input humidity_dec, input temperature_int, input temperature_dec, output ready);
endinterface

interface swhr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [swhr_pkg::CFG_IDX_W-1:0]  index;
	logic [swhr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/single_wire_humidity_sensor_reader.sv]
// Single-wire humidity/temperature sensor reader, one input word per microsecond tick.
// Each result word is formed combinationally and registered into the result buffer.
// Input words are taken one per clock while the result buffer is not full.
// A two-entry result buffer keeps input flowing while one result waits at the output.
// Reset: phase idle, counters and shift word cleared, registers at their defaults.
module single_wire_humidity_sensor_reader (
	input logic        clk,
	input logic        arst_n,
	swhr_in_if.sink    item,
	swhr_out_if.source result,
	swhr_cfg_if.sink   cfg
);

	swhr_pkg::cfg_t cfg_regs;
	swhr_pkg::res_t seq_res;
	swhr_pkg::res_t head;
	logic           buf_full;
	logic           accept;

	assign cfg.ready  = 1'b1;
	assign item.ready = !buf_full;
	assign accept     = item.valid && !buf_full;

	swhr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	swhr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (item.kind),
		.line_in (item.line_in),
		.cfg     (cfg_regs),
		.result  (seq_res)
	);

	swhr_res_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (seq_res),
		.full      (buf_full),
		.valid     (result.valid),
		.pop       (result.valid && result.ready),
		.pop_data  (head)
	);

	assign result.drive_enable    = head.drive_enable;
	assign result.drive_level     = head.drive_level;
	assign result.busy_res        = head.busy_res;
	assign result.done_res        = head.done_res;
	assign result.checksum_ok     = head.checksum_ok;
	assign result.timed_out       = head.timed_out;
	assign result.humidity_int    = head.humidity_int;
	assign result.humidity_dec    = head.humidity_dec;
	assign result.temperature_int = head.temperature_int;
	assign result.temperature_dec = head.temperature_dec;

endmodule

[sv/swhr_cfg_regs.sv]
// Configuration register file, written one word per handshake.
module swhr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [swhr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [swhr_pkg::CFG_DATA_W-1:0] wr_data,
	output swhr_pkg::cfg_t                  cfg
);

	swhr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks  <= swhr_pkg::START_LOW_RESET;
			cfg_q.release_ticks    <= swhr_pkg::RELEASE_RESET;
			cfg_q.response_timeout <= swhr_pkg::RESP_TIMEOUT_RESET;
			cfg_q.one_threshold    <= swhr_pkg::ONE_THRESH_RESET;
			cfg_q.data_timeout     <= swhr_pkg::DATA_TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				swhr_pkg::REG_START_LOW:    cfg_q.start_low_ticks  <= wr_data;
				swhr_pkg::REG_RELEASE:      cfg_q.release_ticks    <= wr_data[7:0];
				swhr_pkg::REG_RESP_TIMEOUT: cfg_q.response_timeout <= wr_data[7:0];
				swhr_pkg::REG_ONE_THRESH:   cfg_q.one_threshold    <= wr_data[7:0];
				swhr_pkg::REG_DATA_TIMEOUT: cfg_q.data_timeout     <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/swhr_seq.sv]
// Read sequencer: phase, tick counter, bit counter and received shift word.
module swhr_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           kind,
	input  logic           line_in,
	input  swhr_pkg::cfg_t cfg,
	output swhr_pkg::res_t result
);

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_DRV_LOW   = 3'd1,
		PH_DRV_HIGH  = 3'd2,
		PH_RESP_LOW  = 3'd3,
		PH_RESP_HIGH = 3'd4,
		PH_DATA_LOW  = 3'd5,
		PH_DATA_HIGH = 3'd6
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [swhr_pkg::COUNT_W-1:0]       tick_q, tick_d, bumped;
	logic [swhr_pkg::BIT_IDX_W-1:0]     bit_q, bit_d;
	logic [swhr_pkg::WORD_W-1:0]        word_q, word_d, shifted;
	logic [swhr_pkg::COUNT_W-1:0]       resp_lim, data_lim, thresh;
	logic                               last_bit;
	logic [9:0]                         sum;
	logic                               done, tout, ok;
	logic [swhr_pkg::WORD_W-1:0]        bytes;

	assign bumped   = (tick_q == swhr_pkg::COUNT_MAX) ? tick_q : tick_q + 1'b1;
	assign resp_lim = {7'd0, cfg.response_timeout};
	assign data_lim = {7'd0, cfg.data_timeout};
	assign thresh   = {7'd0, cfg.one_threshold};
	assign shifted  = {word_q[swhr_pkg::WORD_W-2:0], (tick_q > thresh)};
	assign last_bit = ({1'b0, bit_q} + 7'd1) >= 7'(swhr_pkg::FRAME_BITS);
	assign sum      = {2'd0, shifted[39:32]} + {2'd0, shifted[31:24]}
		+ {2'd0, shifted[23:16]} + {2'd0, shifted[15:8]};

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		word_d  = word_q;
		done    = 1'b0;
		tout    = 1'b0;
		ok      = 1'b0;
		bytes   = '0;
		if (kind == swhr_pkg::KIND_START) begin
			if (phase_q == PH_IDLE) begin
				phase_d = PH_DRV_LOW;
				tick_d  = '0;
				bit_d   = '0;
				word_d  = '0;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_DRV_LOW: begin
					tick_d = bumped;
					if (bumped >= cfg.start_low_ticks) begin
						phase_d = PH_DRV_HIGH;
						tick_d  = '0;
					end
				end
				PH_DRV_HIGH: begin
					tick_d = bumped;
					if (bumped >= {7'd0, cfg.release_ticks}) begin
						phase_d = PH_RESP_LOW;
						tick_d  = '0;
					end
				end
				PH_RESP_LOW: begin
					if (line_in || tick_q > resp_lim) begin
						phase_d = PH_RESP_HIGH;
						tick_d  = '0;
					end else begin
						tick_d = bumped;
					end
				end
				PH_RESP_HIGH: begin
					if (!line_in || tick_q > resp_lim) begin
						phase_d = PH_DATA_LOW;
						tick_d  = '0;
					end else begin
						tick_d = bumped;
					end
				end
				PH_DATA_LOW: begin
					if (line_in) begin
						phase_d = PH_DATA_HIGH;
						tick_d  = '0;
					end else begin
						tick_d = bumped;
						if (bumped > data_lim) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
							tout    = 1'b1;
						end
					end
				end
				PH_DATA_HIGH: begin
					if (line_in) begin
						tick_d = bumped;
						if (bumped > data_lim) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
							tout    = 1'b1;
						end
					end else begin
						// the low sample closes the pulse and decides the bit
						word_d = shifted;
						tick_d = '0;
						if (last_bit) begin
							ok      = (sum[7:0] == shifted[7:0]);
							bytes   = shifted;
							done    = 1'b1;
							phase_d = PH_IDLE;
							bit_d   = '0;
						end else begin
							bit_d   = bit_q + 1'b1;
							phase_d = PH_DATA_LOW;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			word_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			word_q  <= word_d;
		end
	end

	always_comb begin
		result.drive_enable    = (phase_d == PH_DRV_LOW) || (phase_d == PH_DRV_HIGH);
		result.drive_level     = (phase_d == PH_DRV_HIGH);
		result.busy_res        = (phase_d != PH_IDLE);
		result.done_res        = done;
		result.checksum_ok     = ok;
		result.timed_out       = tout;
		result.humidity_int    = bytes[39:32];
		result.humidity_dec    = bytes[31:24];
		result.temperature_int = bytes[23:16];
		result.temperature_dec = bytes[15:8];
	end

endmodule

[sv/swhr_res_buf.sv]
// Two-entry result buffer that decouples the input side from a stalled output.
module swhr_res_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swhr_pkg::res_t push_data,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output swhr_pkg::res_t pop_data
);

	swhr_pkg::res_t entry_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[tb/sv/tb_single_wire_humidity_sensor_reader.sv]
// Testbench for the single-wire humidity sensor reader: scripted and random reads, checked word by word.
module tb_single_wire_humidity_sensor_reader;
	timeunit 1ns;
	timeprecision 1ps;

	import swhr_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 180;

	typedef enum logic [2:0] {
		P_IDLE,
		P_DRV_LOW,
		P_DRV_HIGH,
		P_RESP_LOW,
		P_RESP_HIGH,
		P_DATA_LOW,
		P_DATA_HIGH
	} read_phase_t;

	typedef struct packed {
		logic kind;
		logic line_in;
	} sample_t;

	logic clk    = 1'b1;
	logic arst_n = 1'b0;

	swhr_in_if  item_ch();
	swhr_out_if res_ch();
	swhr_cfg_if cfg_ch();

	single_wire_humidity_sensor_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	logic                  word_valid = 1'b0;
	logic                  word_kind  = KIND_TICK;
	logic                  word_line  = 1'b0;
	logic                  word_taken = 1'b0;
	logic                  res_ready  = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	assign item_ch.valid   = word_valid;
	assign item_ch.kind    = word_kind;
	assign item_ch.line_in = word_line;
	assign res_ch.ready    = res_ready;
	assign cfg_ch.valid    = cfg_valid;
	assign cfg_ch.index    = cfg_index;
	assign cfg_ch.data     = cfg_data;

	sample_t pending_q[$];
	res_t    expected_q[$];
	sample_t next_word;

	// register file and read sequencer as the block should hold them
	cfg_t                 reg_model;
	read_phase_t          rd_phase;
	logic [COUNT_W-1:0]   rd_count;
	logic [BIT_IDX_W-1:0] rd_bits;
	logic [WORD_W-1:0]    rd_word;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int idle_send[4]   = '{0, 84, 0, 37};
	int idle_recv[4]   = '{0, 0, 84, 37};

	int errors        = 0;
	int words_checked = 0;
	int reads_done    = 0;
	int reads_aborted = 0;
	int sums_good     = 0;
	int items_queued  = 0;
	int cycles        = 0;

	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_single_wire_humidity_sensor_reader failed");
			$finish;
		end
	end

	function automatic void count_up();
		if (rd_count != COUNT_MAX)
			rd_count = rd_count + 1'b1;
	endfunction

	function automatic res_t sensor_step(input logic kind, input logic line);
		res_t       r;
		logic       bit_val;
		logic [7:0] sum;
		r = '0;
		if (kind == KIND_START) begin
			// a request during a read changes nothing
			if (rd_phase == P_IDLE) begin
				rd_phase = P_DRV_LOW;
				rd_count = '0;
				rd_bits  = '0;
				rd_word  = '0;
			end
		end else begin
			case (rd_phase)
				P_DRV_LOW: begin
					count_up();
					if (rd_count >= reg_model.start_low_ticks) begin
						rd_phase = P_DRV_HIGH;
						rd_count = '0;
					end
				end
				P_DRV_HIGH: begin
					count_up();
					if (rd_count >= reg_model.release_ticks) begin
						rd_phase = P_RESP_LOW;
						rd_count = '0;
					end
				end
				P_RESP_LOW: begin
					if (line || rd_count > reg_model.response_timeout) begin
						rd_phase = P_RESP_HIGH;
						rd_count = '0;
					end else begin
						count_up();
					end
				end
				P_RESP_HIGH: begin
					if (!line || rd_count > reg_model.response_timeout) begin
						rd_phase = P_DATA_LOW;
						rd_count = '0;
					end else begin
						count_up();
					end
				end
				P_DATA_LOW: begin
					if (line) begin
						rd_phase = P_DATA_HIGH;
						rd_count = '0;
					end else begin
						count_up();
						if (rd_count > reg_model.data_timeout) begin
							rd_phase    = P_IDLE;
							r.done_res  = 1'b1;
							r.timed_out = 1'b1;
						end
					end
				end
				P_DATA_HIGH: begin
					if (line) begin
						count_up();
						if (rd_count > reg_model.data_timeout) begin
							rd_phase    = P_IDLE;
							r.done_res  = 1'b1;
							r.timed_out = 1'b1;
						end
					end else begin
						// the falling sample closes the pulse and decides the bit
						bit_val  = rd_count > reg_model.one_threshold;
						rd_word  = {rd_word[WORD_W-2:0], bit_val};
						rd_count = '0;
						if (int'(rd_bits) + 1 >= FRAME_BITS) begin
							sum = rd_word[39:32] + rd_word[31:24] + rd_word[23:16] + rd_word[15:8];
							r.checksum_ok     = (sum == rd_word[7:0]);
							r.humidity_int    = rd_word[39:32];
							r.humidity_dec    = rd_word[31:24];
							r.temperature_int = rd_word[23:16];
							r.temperature_dec = rd_word[15:8];
							r.done_res        = 1'b1;
							rd_phase          = P_IDLE;
							rd_bits           = '0;
						end else begin
							rd_bits  = rd_bits + 1'b1;
							rd_phase = P_DATA_LOW;
						end
					end
				end
				default: ;
			endcase
		end
		r.drive_enable = (rd_phase == P_DRV_LOW || rd_phase == P_DRV_HIGH);
		r.drive_level  = (rd_phase == P_DRV_HIGH);
		r.busy_res     = (rd_phase != P_IDLE);
		return r;
	endfunction

	// input side: predict on acceptance, load the next word at the falling edge
	always @(posedge clk) begin
		word_taken <= arst_n && word_valid && item_ch.ready;
		if (arst_n && word_valid && item_ch.ready)
			expected_q.push_back(sensor_step(word_kind, word_line));
	end

	always @(negedge clk) begin
		if (!word_valid || word_taken) begin
			if (arst_n && pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_word  = pending_q.pop_front();
				word_valid <= 1'b1;
				word_kind  <= next_word.kind;
				word_line  <= next_word.line_in;
			end else begin
				word_valid <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk)
		res_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic compare_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		got = {res_ch.drive_enable, res_ch.drive_level, res_ch.busy_res, res_ch.done_res,
			res_ch.checksum_ok, res_ch.timed_out, res_ch.humidity_int, res_ch.humidity_dec,
			res_ch.temperature_int, res_ch.temperature_dec};
		if (expected_q.size() == 0) begin
			$display("%0t: result word with none expected, expected nothing actual %h", $time, got);
			errors++;
		end else begin
			want = expected_q.pop_front();
			compare_field("drive_enable", 8'(want.drive_enable), 8'(got.drive_enable));
			compare_field("drive_level", 8'(want.drive_level), 8'(got.drive_level));
			compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
			compare_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
			compare_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
			compare_field("humidity_int", want.humidity_int, got.humidity_int);
			compare_field("humidity_dec", want.humidity_dec, got.humidity_dec);
			compare_field("temperature_int", want.temperature_int, got.temperature_int);
			compare_field("temperature_dec", want.temperature_dec, got.temperature_dec);
			words_checked++;
			if (want.done_res && want.timed_out)
				reads_aborted++;
			else if (want.done_res)
				reads_done++;
			if (want.checksum_ok)
				sums_good++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ready)
			check_result();
	end

	task automatic push_word(input logic kind, input logic line);
		pending_q.push_back('{kind: kind, line_in: line});
		items_queued++;
	endtask

	task automatic push_run(input int n, input logic line);
		repeat (n) push_word(KIND_TICK, line);
	endtask

	// wait until every queued word has been sent and every result checked
	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || word_valid || expected_q.size() != 0);
	endtask

	// drain everything, then tick the line low until the read sequencer is back at idle
	task automatic settle();
		forever begin
			drain();
			if (rd_phase == P_IDLE)
				break;
			push_run(40, 1'b0);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_START_LOW:    reg_model.start_low_ticks  = val[14:0];
			REG_RELEASE:      reg_model.release_ticks    = val[7:0];
			REG_RESP_TIMEOUT: reg_model.response_timeout = val[7:0];
			REG_ONE_THRESH:   reg_model.one_threshold    = val[7:0];
			REG_DATA_TIMEOUT: reg_model.data_timeout     = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// unused upper data bits of the narrow registers get random values
	task automatic write_config(input int sl, input int rel, input int rt, input int thr,
		input int dt);
		write_reg(3'($urandom_range(int'(REG_DATA_TIMEOUT) + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		write_reg(REG_START_LOW, CFG_DATA_W'(sl));
		write_reg(REG_RELEASE, {7'($urandom), 8'(rel)});
		write_reg(REG_RESP_TIMEOUT, {7'($urandom), 8'(rt)});
		write_reg(REG_ONE_THRESH, {7'($urandom), 8'(thr)});
		write_reg(REG_DATA_TIMEOUT, {7'($urandom), 8'(dt)});
	endtask

	function automatic logic [WORD_W-1:0] frame_of(input logic [31:0] data, input bit good);
		logic [7:0] sum;
		sum = data[31:24] + data[23:16] + data[15:8] + data[7:0];
		return {data, good ? sum : 8'($urandom)};
	endfunction

	// a full read as a sensor would answer it; cut below FRAME_BITS stalls the line there
	task automatic send_frame(input logic [WORD_W-1:0] frame, input bit long_resp, input int cut);
		int t;
		int dt;
		int thr;
		int lim;
		int h;
		int n;
		t   = int'(reg_model.response_timeout);
		dt  = int'(reg_model.data_timeout);
		thr = int'(reg_model.one_threshold);
		lim = (thr < dt) ? thr : dt;
		if (lim > 6)
			lim = 6;
		push_word(KIND_START, 1'($urandom));
		n = (reg_model.start_low_ticks == 0) ? 1 : int'(reg_model.start_low_ticks);
		n += (reg_model.release_ticks == 0) ? 1 : int'(reg_model.release_ticks);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_word(KIND_START, 1'($urandom));
			push_word(KIND_TICK, 1'($urandom));
		end
		if (long_resp) begin
			// both response waits run into their timeout
			push_run(t + 2, 1'b0);
			push_run(t + 2, 1'b1);
		end else begin
			push_run($urandom_range(0, (t < 3) ? t : 3), 1'b0);
			push_word(KIND_TICK, 1'b1);
			push_run($urandom_range(0, (t < 3) ? t : 3), 1'b1);
			push_word(KIND_TICK, 1'b0);
		end
		for (int j = 0; j < FRAME_BITS; j++) begin
			if (j == cut) begin
				if ($urandom_range(0, 1) == 1)
					push_run(dt + 2, 1'b0);
				else
					push_run(dt + 3, 1'b1);
				return;
			end
			push_run($urandom_range(0, (dt < 2) ? dt : 2), 1'b0);
			if (frame[FRAME_BITS-1-j])
				h = thr + 2;
			else
				h = $urandom_range(1, lim + 1);
			push_run(h, 1'b1);
			// a pulse past the data limit has already aborted the read
			if (h >= dt + 2)
				return;
			push_word(KIND_TICK, 1'b0);
		end
	endtask

	initial begin
		int thr;
		int dt;
		int budget;
		reg_model = '{start_low_ticks: START_LOW_RESET, release_ticks: RELEASE_RESET,
			response_timeout: RESP_TIMEOUT_RESET, one_threshold: ONE_THRESH_RESET,
			data_timeout: DATA_TIMEOUT_RESET};
		rd_phase = P_IDLE;
		rd_count = '0;
		rd_bits  = '0;
		rd_word  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// scripted reads, no idling on either side
		// reset registers: the start pulse holds the line low through a short run of ticks
		push_word(KIND_TICK, 1'b0);
		push_word(KIND_TICK, 1'b1);
		push_word(KIND_START, 1'b0);
		push_run(24, 1'b1);
		drain();
		write_config(3, 2, 4, 2, 6);
		settle();
		// widest drive times, then shorten them in the middle of the start pulse
		write_config((1 << COUNT_W) - 1, 255, 255, 0, 1);
		push_word(KIND_START, 1'b1);
		push_run(24, 1'b0);
		drain();
		write_config(0, 0, 0, 0, 1);
		send_frame(frame_of(32'hA5C3_3C5A, 1'b0), 1'b1, FRAME_BITS);
		settle();
		write_config(3, 2, 4, 2, 6);
		send_frame(frame_of($urandom, 1'b1), 1'b0, FRAME_BITS);
		send_frame(frame_of($urandom, 1'b1), 1'b0, 0);
		send_frame(frame_of($urandom, 1'b1), 1'b0, FRAME_BITS - 1);
		settle();

		// random reads and line noise, one register setting per idling mode
		for (int m = 0; m < 4; m++) begin
			send_idle_pct  = idle_send[m];
			recv_stall_pct = idle_recv[m];
			thr = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 5);
			if (thr == 255)
				dt = 255;
			else if ($urandom_range(0, 7) == 0)
				dt = $urandom_range(1, 255);
			else
				dt = $urandom_range(thr + 1, thr + 8);
			write_config($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 5), thr, dt);
			budget = items_queued + PHASE_ITEMS;
			while (items_queued < budget) begin
				if ($urandom_range(0, 9) < 7) begin
					send_frame(frame_of($urandom, $urandom_range(0, 3) != 0),
						$urandom_range(0, 9) == 0,
						($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_BITS - 1) : FRAME_BITS);
				end else begin
					repeat ($urandom_range(1, 16))
						push_word(($urandom_range(0, 7) == 0) ? KIND_START : KIND_TICK, 1'($urandom));
				end
			end
			settle();
		end

		repeat (20) @(posedge clk);
		$display("Checked %0d result words from %0d queued input words over 4 random settings.",
			words_checked, items_queued);
		$display("Reads: %0d completed (%0d with a matching checksum), %0d aborted on timeout.",
			reads_done, sums_good, reads_aborted);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_single_wire_humidity_sensor_reader passed");
		else
			$display("tb_single_wire_humidity_sensor_reader failed");
		$finish;
	end

endmodule
